/* rtl/sgd_pkg.sv */
// Shared types and constants for the shake gesture detector.
// No dependencies.
`default_nettype none
package sgd_pkg;

    localparam int INT_W = 17;
    localparam logic [INT_W-1:0] INT_MAX = 17'h1FFFF;

    localparam logic [2:0] REG_SHAKE_THRESHOLD    = 3'd0;
    localparam logic [2:0] REG_WINDOW_MS          = 3'd1;
    localparam logic [2:0] REG_REQUIRED_REVERSALS = 3'd2;
    localparam logic [2:0] REG_COOLDOWN_MS        = 3'd3;
    localparam logic [2:0] REG_ARM_UP_THRESHOLD   = 3'd4;

    localparam logic [15:0] RST_SHAKE_THRESHOLD = 16'd6144;
    localparam logic [15:0] RST_WINDOW_MS       = 16'd500;
    localparam logic [3:0]  RST_REQ_REVERSALS   = 4'd3;
    localparam logic [15:0] RST_COOLDOWN_MS     = 16'd1000;
    localparam logic [15:0] RST_ARM_UP          = 16'd0;

    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    localparam int ALPHA_NUM = 205;

    typedef struct packed {
        logic seed;
        logic filter;
        logic cap_dyn;
        logic cap_sq;
    } lane_ctrl_t;

endpackage
`default_nettype wire

/* rtl/accel_shake_gesture_detector.sv */
// Shake gesture detector top: three axis lanes, merge, square root and decision.
// Clear and seed samples go from the band check straight to the decision stage.
// One transaction in flight; a new one is accepted only after the previous one leaves the decision
// stage, and a stalled result holds the decision stage.
// Reset (synchronous, aresetn low) restores registers and gravity to one g on Z.
// Depends on sgd_pkg, sgd_lane, sgd_isqrt.
`default_nettype none
module accel_shake_gesture_detector #(
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 32
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_we,
    input  wire [2:0]                    cfg_index,
    input  wire [15:0]                   cfg_data,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_command,
    input  wire [31:0]                   s_now_ms,
    input  wire signed [SAMPLE_BITS-1:0] s_accel_x,
    input  wire signed [SAMPLE_BITS-1:0] s_accel_y,
    input  wire signed [SAMPLE_BITS-1:0] s_accel_z,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_event_res,
    output logic [16:0]                  m_intensity,
    output logic                         m_in_cooldown,
    output logic                         m_arm_up
);
    localparam int S   = SAMPLE_BITS;
    localparam int GW  = S + 16;
    localparam int DW  = S + 2;
    localparam int AW  = S + 1;
    localparam int SQW = 2 * S + 2;
    localparam int RW  = S + 1;
    localparam int BW  = 2 * S + 9;
    localparam int CW  = (SQW > 32) ? SQW : 32;
    localparam int YW  = S + 4;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BAND = 3'd1;
    localparam logic [2:0] ST_GRAV = 3'd2;
    localparam logic [2:0] ST_DYN  = 3'd3;
    localparam logic [2:0] ST_SQ   = 3'd4;
    localparam logic [2:0] ST_SUM  = 3'd5;
    localparam logic [2:0] ST_ROOT = 3'd6;
    localparam logic [2:0] ST_DEC  = 3'd7;

    logic [2:0] state_reg, state_next;

    logic [15:0] thr_reg, win_reg, cd_reg;
    logic [3:0]  req_reg;
    logic signed [15:0] arm_thr_reg;

    logic                 cmd_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic signed [S-1:0]  ax_reg, ay_reg, az_reg;
    logic                 band_reg;

    logic                 bv_reg, bv_next;
    logic signed [YW-1:0] sgy_reg, sgy_next;
    logic [TIME_BITS-1:0] lst_reg, lst_next, fpt_reg, fpt_next;
    logic [3:0]           rc_reg, rc_next;
    logic [1:0]           ls_reg, ls_next;
    logic [16:0]          pk_reg, pk_next;

    logic        m_valid_reg;
    logic        ev_reg, cool_reg, arm_reg;
    logic [16:0] int_reg;

    sgd_pkg::lane_ctrl_t ctrl;
    logic [2*S-1:0]         ssq_x, ssq_y, ssq_z;
    logic signed [GW-1:0]   gx, gy, gz;
    logic signed [DW-1:0]   dx, dy, dz;
    logic [AW-1:0]          ex, ey, ez;
    logic [2*AW-1:0]        qx, qy, qz;

    logic [BW-1:0]  band_t;
    logic           band_ok;
    logic [SQW-1:0] sq_sum, sq_reg;
    logic           isq_start, isq_busy;
    logic [RW-1:0]  root;
    logic [16:0]    mag;
    logic           out_free;

    logic                 ev_c, cool_c, arm_c;
    logic [16:0]          int_c;
    logic [TIME_BITS-1:0] d_lst, d_fpt, d_cool;
    logic                 strong_hit;
    logic signed [DW-1:0] dom;
    logic [1:0]           sgn;
    logic [3:0]           rc_inc;
    logic [16:0]          pk_max;

    assign ctrl.seed    = (state_reg == ST_BAND) && !cmd_reg && !bv_reg;
    assign ctrl.filter  = (state_reg == ST_GRAV) && band_reg;
    assign ctrl.cap_dyn = (state_reg == ST_DYN);
    assign ctrl.cap_sq  = (state_reg == ST_SQ);

    sgd_lane #(.SAMPLE_BITS(S)) u_lane_x (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .reset_one_g(1'b0),
        .sample(ax_reg), .samp_sq(ssq_x), .grav(gx), .dyn(dx), .dyn_abs(ex), .dyn_sq(qx)
    );
    sgd_lane #(.SAMPLE_BITS(S)) u_lane_y (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .reset_one_g(1'b0),
        .sample(ay_reg), .samp_sq(ssq_y), .grav(gy), .dyn(dy), .dyn_abs(ey), .dyn_sq(qy)
    );
    sgd_lane #(.SAMPLE_BITS(S)) u_lane_z (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .reset_one_g(1'b1),
        .sample(az_reg), .samp_sq(ssq_z), .grav(gz), .dyn(dz), .dyn_abs(ez), .dyn_sq(qz)
    );

    assign band_t = (BW'(ssq_x) + BW'(ssq_y) + BW'(ssq_z)) * BW'(100);
    assign band_ok = (band_t >= (BW'(49) << 24)) && (band_t <= (BW'(169) << 24));

    assign sq_sum = SQW'(qx) + SQW'(qy) + SQW'(qz);
    assign isq_start = (state_reg == ST_SUM);

    sgd_isqrt #(.RW(RW)) u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .start(isq_start), .value(sq_sum),
        .busy(isq_busy), .root(root)
    );

    assign mag = (32'(root) > 32'(sgd_pkg::INT_MAX)) ? sgd_pkg::INT_MAX : 17'(root);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_BAND;
            ST_BAND: state_next = (cmd_reg || !bv_reg) ? ST_DEC : ST_GRAV;
            ST_GRAV: state_next = ST_DYN;
            ST_DYN:  state_next = ST_SQ;
            ST_SQ:   state_next = ST_SUM;
            ST_SUM:  state_next = ST_ROOT;
            ST_ROOT: if (!isq_busy) state_next = ST_DEC;
            ST_DEC:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        bv_next  = bv_reg;
        sgy_next = sgy_reg;
        lst_next = lst_reg;
        fpt_next = fpt_reg;
        rc_next  = rc_reg;
        ls_next  = ls_reg;
        pk_next  = pk_reg;
        ev_c     = 1'b0;
        int_c    = '0;
        d_lst    = now_reg - lst_reg;
        d_fpt    = now_reg - fpt_reg;
        strong_hit = CW'(sq_reg) >= CW'(thr_reg) * CW'(thr_reg);
        dom      = dx;
        if (ey > ex && ey >= ez) begin
            dom = dy;
        end else if (ez > ex && ez > ey) begin
            dom = dz;
        end
        sgn    = dom[DW-1] ? sgd_pkg::SIGN_NEG : sgd_pkg::SIGN_POS;
        rc_inc = rc_reg + 4'd1;
        pk_max = (mag > pk_reg) ? mag : pk_reg;
        if (cmd_reg) begin
            rc_next  = '0;
            ls_next  = sgd_pkg::SIGN_NONE;
            fpt_next = '0;
            pk_next  = '0;
            sgy_next = '0;
            bv_next  = 1'b0;
        end else if (!bv_reg) begin
            sgy_next = YW'(ay_reg);
            bv_next  = 1'b1;
        end else begin
            int_c = mag;
            if (32'(d_lst) < 32'(cd_reg)) begin
                rc_next = '0;
                ls_next = sgd_pkg::SIGN_NONE;
            end else begin
                if (rc_reg != 4'd0 && 32'(d_fpt) > 32'(win_reg)) begin
                    rc_next = '0;
                    ls_next = sgd_pkg::SIGN_NONE;
                end
                if (strong_hit) begin
                    if (rc_next == 4'd0) begin
                        sgy_next = YW'(gy >>> 12);
                        fpt_next = now_reg;
                        rc_next  = 4'd1;
                        ls_next  = sgn;
                        pk_next  = mag;
                    end else if (sgn != ls_next) begin
                        rc_next = rc_inc;
                        ls_next = sgn;
                        pk_next = pk_max;
                        if (rc_inc >= req_reg) begin
                            lst_next = now_reg;
                            rc_next  = '0;
                            ls_next  = sgd_pkg::SIGN_NONE;
                            ev_c     = 1'b1;
                            int_c    = pk_max;
                        end
                    end
                end
            end
        end
        d_cool = now_reg - lst_next;
        cool_c = 32'(d_cool) < 32'(cd_reg);
        arm_c  = sgy_next <= YW'(arm_thr_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            thr_reg     <= sgd_pkg::RST_SHAKE_THRESHOLD;
            win_reg     <= sgd_pkg::RST_WINDOW_MS;
            req_reg     <= sgd_pkg::RST_REQ_REVERSALS;
            cd_reg      <= sgd_pkg::RST_COOLDOWN_MS;
            arm_thr_reg <= sgd_pkg::RST_ARM_UP;
            bv_reg      <= 1'b0;
            sgy_reg     <= '0;
            lst_reg     <= '0;
            fpt_reg     <= '0;
            rc_reg      <= '0;
            ls_reg      <= sgd_pkg::SIGN_NONE;
            pk_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    sgd_pkg::REG_SHAKE_THRESHOLD:    thr_reg     <= cfg_data;
                    sgd_pkg::REG_WINDOW_MS:          win_reg     <= cfg_data;
                    sgd_pkg::REG_REQUIRED_REVERSALS: req_reg     <= cfg_data[3:0];
                    sgd_pkg::REG_COOLDOWN_MS:        cd_reg      <= cfg_data;
                    sgd_pkg::REG_ARM_UP_THRESHOLD:   arm_thr_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DEC && out_free) begin
                bv_reg      <= bv_next;
                sgy_reg     <= sgy_next;
                lst_reg     <= lst_next;
                fpt_reg     <= fpt_next;
                rc_reg      <= rc_next;
                ls_reg      <= ls_next;
                pk_reg      <= pk_next;
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_command;
            now_reg <= s_now_ms[TIME_BITS-1:0];
            ax_reg  <= s_accel_x;
            ay_reg  <= s_accel_y;
            az_reg  <= s_accel_z;
        end
        if (state_reg == ST_BAND) begin
            band_reg <= band_ok;
        end
        if (state_reg == ST_SUM) begin
            sq_reg <= sq_sum;
        end
        if (state_reg == ST_DEC && out_free) begin
            ev_reg   <= ev_c;
            int_reg  <= int_c;
            cool_reg <= cool_c;
            arm_reg  <= arm_c;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_event_res   = ev_reg;
    assign m_intensity   = int_reg;
    assign m_in_cooldown = cool_reg;
    assign m_arm_up      = arm_reg;
endmodule
`default_nettype wire

/* rtl/sgd_lane.sv */
// One axis lane: gravity estimate, dynamic component and its square.
// Depends on sgd_pkg.
`default_nettype none
module sgd_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  sgd_pkg::lane_ctrl_t          ctrl,
    input  wire                          reset_one_g,
    input  wire signed [SAMPLE_BITS-1:0] sample,
    output logic [2*SAMPLE_BITS-1:0]     samp_sq,
    output logic signed [SAMPLE_BITS+15:0] grav,
    output logic signed [SAMPLE_BITS+1:0]  dyn,
    output logic [SAMPLE_BITS:0]           dyn_abs,
    output logic [2*SAMPLE_BITS+1:0]       dyn_sq
);
    localparam int GW = SAMPLE_BITS + 16;
    localparam int DW = SAMPLE_BITS + 2;
    localparam int AW = SAMPLE_BITS + 1;

    logic signed [GW-1:0]   grav_reg;
    logic signed [DW-1:0]   dyn_reg;
    logic [AW-1:0]          abs_reg;
    logic [2*AW-1:0]        sq_reg;
    logic signed [GW-1:0]   q;
    logic signed [GW:0]     diff;
    logic signed [GW+8:0]   prod;
    logic signed [GW-1:0]   grav_next;
    logic signed [GW+1:0]   t;
    logic signed [DW-1:0]   d;
    logic [AW-1:0]          a_next;

    assign q = {{4{sample[SAMPLE_BITS-1]}}, sample, 12'd0};
    assign samp_sq = unsigned'((2*SAMPLE_BITS)'(sample) * (2*SAMPLE_BITS)'(sample));
    assign diff = (GW+1)'(q) - (GW+1)'(grav_reg);
    assign prod = (GW+9)'(diff) * (GW+9)'(sgd_pkg::ALPHA_NUM);
    assign grav_next = grav_reg + GW'(prod >>> 12);
    assign t = (GW+2)'(q) - (GW+2)'(grav_reg) + (GW+2)'(2048);
    assign d = DW'(t >>> 12);
    assign a_next = d[DW-1] ? AW'(-d) : AW'(d);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg <= reset_one_g ? GW'(25'd16777216) : '0;
        end else if (ctrl.seed) begin
            grav_reg <= q;
        end else if (ctrl.filter) begin
            grav_reg <= grav_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.cap_dyn) begin
            dyn_reg <= d;
            abs_reg <= a_next;
        end
        if (ctrl.cap_sq) begin
            sq_reg <= (2*AW)'(abs_reg) * (2*AW)'(abs_reg);
        end
    end

    assign grav = grav_reg;
    assign dyn = dyn_reg;
    assign dyn_abs = abs_reg;
    assign dyn_sq = sq_reg;
endmodule
`default_nettype wire

/* rtl/sgd_isqrt.sv */
// Iterative integer square root, one result bit per cycle.
// No dependencies on other files.
`default_nettype none
module sgd_isqrt #(
    parameter int RW = 17
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              start,
    input  wire [2*RW-1:0]   value,
    output logic             busy,
    output logic [RW-1:0]    root
);
    localparam int CNW = $clog2(RW + 1);

    logic [2*RW-1:0] v_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [CNW-1:0]  cnt_reg;
    logic            busy_reg;
    logic [RW+3:0]   sh;
    logic [RW+3:0]   trial;

    assign sh = {rem_reg, v_reg[2*RW-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNW'(RW);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CNW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg    <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            v_reg <= {v_reg[2*RW-3:0], 2'b00};
            if (sh >= trial) begin
                rem_reg  <= (RW+2)'(sh - trial);
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_reg  <= (RW+2)'(sh);
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

/* tb/sv/accel_shake_gesture_detector_test.sv */
// Self-checking testbench for the shake gesture detector: drives samples and clears,
// predicts each result with an in-bench model of gravity, dynamics and reversal logic.
// Depends on sgd_pkg and accel_shake_gesture_detector.
`timescale 1ns / 100ps
`default_nettype none
module accel_shake_gesture_detector_test;

    typedef struct packed {
        logic        event_res;
        logic [16:0] intensity;
        logic        in_cooldown;
        logic        arm_up;
    } shake_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_command = 1'b0;
    logic [31:0] s_now_ms = '0;
    logic signed [15:0] s_accel_x = '0, s_accel_y = '0, s_accel_z = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_event_res;
    logic [16:0] m_intensity;
    logic        m_in_cooldown;
    logic        m_arm_up;

    accel_shake_gesture_detector dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_now_ms(s_now_ms), .s_accel_x(s_accel_x), .s_accel_y(s_accel_y),
        .s_accel_z(s_accel_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_event_res(m_event_res),
        .m_intensity(m_intensity), .m_in_cooldown(m_in_cooldown), .m_arm_up(m_arm_up)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // predictor state
    logic [15:0] thr_q;
    logic [15:0] win_q;
    logic [3:0]  req_q;
    logic [15:0] cool_q;
    logic signed [15:0] armthr_q;
    longint grav_x, grav_y, grav_z;
    longint start_gy;
    logic [31:0] last_shake_t, first_peak_t;
    int unsigned rev_count;
    logic [1:0]  last_sgn;
    longint unsigned peak_mag;
    bit seeded;

    shake_result_t expected_results[$];
    int mismatches = 0;
    int results_seen = 0;
    int events_seen = 0;
    bit idle_en = 1'b1;
    logic [31:0] clock_ms = 32'd0;

    function automatic longint floor_q12(longint x);
        return x >>> 12;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic clear_seq();
        rev_count = 0;
        last_sgn = sgd_pkg::SIGN_NONE;
        first_peak_t = 0;
        peak_mag = 0;
        start_gy = 0;
        seeded = 0;
    endtask

    task automatic predict_shake(input logic cmd, input logic [31:0] now,
                                 input logic signed [15:0] ax16,
                                 input logic signed [15:0] ay16,
                                 input logic signed [15:0] az16);
        longint ax, ay, az, qx, qy, qz, dx, dy, dz, dom;
        longint unsigned tot, ex, ey, ez, sq, mag, lim;
        logic [1:0] sgn;
        shake_result_t r;
        ax = ax16; ay = ay16; az = az16;
        qx = ax * 4096; qy = ay * 4096; qz = az * 4096;
        r = '0;
        if (cmd) begin
            clear_seq();
        end else if (!seeded) begin
            grav_x = qx; grav_y = qy; grav_z = qz;
            start_gy = ay;
            seeded = 1;
        end else begin
            tot = ax * ax + ay * ay + az * az;
            lim = 64'd1 << 24;
            if (tot * 100 >= 49 * lim && tot * 100 <= 169 * lim) begin
                grav_x += floor_q12((qx - grav_x) * 205);
                grav_y += floor_q12((qy - grav_y) * 205);
                grav_z += floor_q12((qz - grav_z) * 205);
            end
            dx = floor_q12(qx - grav_x + 2048);
            dy = floor_q12(qy - grav_y + 2048);
            dz = floor_q12(qz - grav_z + 2048);
            ex = dx < 0 ? -dx : dx;
            ey = dy < 0 ? -dy : dy;
            ez = dz < 0 ? -dz : dz;
            sq = ex * ex + ey * ey + ez * ez;
            mag = root_floor(sq);
            if (mag > 131071) mag = 131071;
            r.intensity = mag[16:0];
            if (32'(now - last_shake_t) < {16'd0, cool_q}) begin
                rev_count = 0;
                last_sgn = sgd_pkg::SIGN_NONE;
            end else begin
                if (rev_count > 0 && 32'(now - first_peak_t) > {16'd0, win_q}) begin
                    rev_count = 0;
                    last_sgn = sgd_pkg::SIGN_NONE;
                end
                if (sq >= longint'(thr_q) * longint'(thr_q)) begin
                    dom = dx;
                    if (ey > ex && ey >= ez) dom = dy;
                    else if (ez > ex && ez > ey) dom = dz;
                    sgn = dom >= 0 ? sgd_pkg::SIGN_POS : sgd_pkg::SIGN_NEG;
                    if (rev_count == 0) begin
                        start_gy = floor_q12(grav_y);
                        first_peak_t = now;
                        rev_count = 1;
                        last_sgn = sgn;
                        peak_mag = mag;
                    end else if (sgn != last_sgn) begin
                        rev_count = (rev_count + 1) & 15;
                        last_sgn = sgn;
                        if (mag > peak_mag) peak_mag = mag;
                        if (rev_count >= req_q) begin
                            last_shake_t = now;
                            rev_count = 0;
                            last_sgn = sgd_pkg::SIGN_NONE;
                            r.event_res = 1'b1;
                            r.intensity = peak_mag[16:0];
                        end
                    end
                end
            end
        end
        r.in_cooldown = 32'(now - last_shake_t) < {16'd0, cool_q};
        r.arm_up = start_gy <= longint'(armthr_q);
        expected_results.push_back(r);
    endtask

    task automatic idle_gap();
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    task automatic send_sample(input logic cmd, input logic [31:0] now,
                               input logic signed [15:0] ax, input logic signed [15:0] ay,
                               input logic signed [15:0] az);
        idle_gap();
        s_valid <= 1'b1;
        s_command <= cmd;
        s_now_ms <= now;
        s_accel_x <= ax;
        s_accel_y <= ay;
        s_accel_z <= az;
        predict_shake(cmd, now, ax, ay, az);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            sgd_pkg::REG_SHAKE_THRESHOLD:    thr_q = val;
            sgd_pkg::REG_WINDOW_MS:          win_q = val;
            sgd_pkg::REG_REQUIRED_REVERSALS: req_q = val[3:0];
            sgd_pkg::REG_COOLDOWN_MS:        cool_q = val;
            sgd_pkg::REG_ARM_UP_THRESHOLD:   armthr_q = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] thr, input logic [15:0] win,
                             input logic [3:0] req, input logic [15:0] cool,
                             input logic [15:0] arm);
        drain();
        write_reg(sgd_pkg::REG_SHAKE_THRESHOLD, thr);
        write_reg(sgd_pkg::REG_WINDOW_MS, win);
        write_reg(sgd_pkg::REG_REQUIRED_REVERSALS, {12'd0, req});
        write_reg(sgd_pkg::REG_COOLDOWN_MS, cool);
        write_reg(sgd_pkg::REG_ARM_UP_THRESHOLD, arm);
        cfg_we <= 1'b0;
    endtask

    // shake burst: alternating strong samples around one g, with random content
    task automatic shake_burst(input int n, input int step_max);
        int k, axis;
        logic signed [15:0] v[3];
        logic signed [15:0] amp;
        for (k = 0; k < n; k++) begin
            clock_ms += $urandom_range(0, step_max);
            v[0] = 16'($urandom_range(0, 600) - 300);
            v[1] = 16'($urandom_range(0, 600) - 300);
            v[2] = 16'sd4096 + $signed(16'($urandom_range(0, 600))) - 16'sd300;
            axis = $urandom_range(0, 2);
            amp = 16'($urandom_range(4000, 20000));
            v[axis] = v[axis] + ((k % 2) ? -amp : amp);
            send_sample(1'b0, clock_ms, v[0], v[1], v[2]);
        end
    endtask

    task automatic test_directed();
        clock_ms = 32'd100;
        send_sample(1'b0, clock_ms, 16'sd0, -16'sd4096, 16'sd0);
        send_sample(1'b0, clock_ms + 1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_sample(1'b0, clock_ms + 2, 16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(1'b0, clock_ms + 3, 16'sd2867, 16'sd0, 16'sd0);
        send_sample(1'b0, clock_ms + 4, 16'sd5325, 16'sd0, 16'sd0);
        send_sample(1'b0, clock_ms + 5, 16'sd8000, 16'sd8000, 16'sd8000);
        send_sample(1'b0, clock_ms + 6, 16'sd8000, 16'sd0, -16'sd8000);
        send_sample(1'b0, clock_ms + 7, -16'sd9000, 16'sd9000, 16'sd0);
        send_sample(1'b1, clock_ms + 8, 16'sd1, 16'sd2, 16'sd3);
        send_sample(1'b0, 32'hFFFF_FFF0, 16'sd0, 16'sd4096, 16'sd0);
        send_sample(1'b0, 32'hFFFF_FFFF, 16'sd20000, 16'sd0, 16'sd0);
        send_sample(1'b0, 32'h0000_0005, -16'sd20000, 16'sd0, 16'sd0);
        send_sample(1'b0, 32'h0000_0009, 16'sd20000, 16'sd0, 16'sd0);
        send_sample(1'b0, 32'h0000_0200, 16'sd0, 16'sd0, 16'sd20000);
        send_sample(1'b0, 32'h0000_0900, 16'sd0, 16'sd0, -16'sd20000);
        send_sample(1'b0, 32'h0000_0950, 16'sd0, 16'sd0, 16'sd20000);
        send_sample(1'b0, 32'h0000_0F00, 16'sd0, 16'sd0, -16'sd20000);
        clock_ms = 32'h1000;
    endtask

    task automatic test_extreme_config();
        configure(16'd0, 16'd0, 4'd1, 16'd0, 16'sh8000);
        shake_burst(12, 3);
        configure(16'hFFFF, 16'hFFFF, 4'd15, 16'hFFFF, 16'sh7FFF);
        shake_burst(12, 3);
        send_sample(1'b1, clock_ms, 16'sd0, 16'sd0, 16'sd0);
        configure(16'd4000, 16'hFFFF, 4'd15, 16'd0, 16'sh7FFF);
        send_sample(1'b0, clock_ms, 16'sd0, 16'sd0, 16'sd4096);
        shake_burst(20, 5);
    endtask

    task automatic test_random(input int n);
        int done, len;
        done = 0;
        while (done < n) begin
            case ($urandom_range(0, 9))
                0: begin
                    clock_ms += $urandom_range(0, 3000);
                    send_sample(1'b0, clock_ms, 16'($urandom), 16'($urandom), 16'($urandom));
                    done++;
                end
                1: begin
                    send_sample(1'b1, $urandom, 16'($urandom), 16'($urandom),
                                16'($urandom));
                    done++;
                end
                2: begin
                    clock_ms += $urandom_range(0, 2000);
                    send_sample(1'b0, clock_ms, 16'($urandom_range(0, 2000) - 1000),
                                16'($urandom_range(0, 2000) - 1000), 16'sd4096);
                    done++;
                end
                default: begin
                    len = $urandom_range(2, 8);
                    shake_burst(len, 200);
                    done += len;
                end
            endcase
        end
    endtask

    initial begin
        thr_q = sgd_pkg::RST_SHAKE_THRESHOLD;
        win_q = sgd_pkg::RST_WINDOW_MS;
        req_q = sgd_pkg::RST_REQ_REVERSALS;
        cool_q = sgd_pkg::RST_COOLDOWN_MS;
        armthr_q = sgd_pkg::RST_ARM_UP;
        grav_x = 0; grav_y = 0; grav_z = longint'(4096) * 4096;
        last_shake_t = 0;
        clear_seq();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_extreme_config();
        configure(16'd6144, 16'd500, 4'd3, 16'd200, 16'd0);
        test_random(500);
        configure(16'd3000, 16'd800, 4'd2, 16'd50, -16'sd2000);
        test_random(450);
        idle_en = 1'b0;
        configure(sgd_pkg::RST_SHAKE_THRESHOLD, sgd_pkg::RST_WINDOW_MS,
                  sgd_pkg::RST_REQ_REVERSALS, 16'd100, 16'd0);
        test_random(250);
        drain();
        $display("Checked %0d results, %0d shake events, over several register settings.",
                 results_seen, events_seen);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // output stall
    initial begin
        int n;
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            if (idle_en) begin
                n = $urandom_range(1, 18);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        shake_result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_event_res, m_intensity, m_in_cooldown, m_arm_up};
            results_seen++;
            if (m_event_res) events_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: expected %p, actual %p", results_seen,
                                 want, got);
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
